// ===== src/bary_pkg.sv =====
// ----------------------------------------------------------------------------
// bary_pkg: shared constants for the barycentric weight pipeline
// Axis count and the slot of each weight in the weight lanes.
// ----------------------------------------------------------------------------
package bary_pkg;

   localparam int AXES    = 3;
   localparam int WEIGHTS = 3;

   localparam int IDX_U = 0;
   localparam int IDX_V = 1;
   localparam int IDX_W = 2;

endpackage

// ===== src/barycentric_coordinates.sv =====
// ----------------------------------------------------------------------------
// barycentric_coordinates: pipelined barycentric weights of a 3D triangle
// Edge vectors, dot products, Gram determinant, then a restoring division
// per weight with round-to-nearest and saturation to signed Q3.F.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one beat carries corners A, B, C and query point P, twelve
//   signed coordinates of COORD_BITS each, packed A.x A.y A.z B.x ... P.z
//   from the lowest bit up.
//   rsp channel: one beat per request with weights u, v, w (signed,
//   WEIGHT_FRAC_BITS fraction bits, WEIGHT_FRAC_BITS + 4 bits wide) in tdata
//   and the degenerate flag in tuser. A zero determinant gives the flag and
//   three zero weights.
//   Throughput: one beat per cycle while the receiver does not stall. Stages:
//   seven setup stages (the first loaded at the accepting edge), one range
//   check, one stage per quotient bit of the divider, then one output
//   register that drives rsp_tvalid.
//   Stall: the whole pipeline advances on one enable, high while the
//   output register is empty or being taken; req_tready follows it, so a
//   stalled receiver holds every stage and nothing is lost or repeated.
//   Reset: synchronous, clears all stage valid bits; payload is not reset.
// ----------------------------------------------------------------------------
module barycentric_coordinates #(
   parameter int COORD_BITS       = 16,
   parameter int WEIGHT_FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   // tdata: corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y,
   //        corner_b_z, corner_c_x, corner_c_y, corner_c_z, query_x,
   //        query_y, query_z (lowest bits first), zero padded to bytes
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  logic [((12*COORD_BITS+7)/8)*8-1:0]        req_tdata,
   // tdata: weight_u, weight_v, weight_w (lowest bits first), zero padded
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   output logic [((3*(WEIGHT_FRAC_BITS+4)+7)/8)*8-1:0] rsp_tdata,
   // tuser: degenerate
   output logic                                      rsp_tuser
);

   localparam int CW    = COORD_BITS;
   localparam int EW    = CW + 1;          // edge component
   localparam int PW    = 2 * EW;          // component product
   localparam int DW    = PW + 2;          // dot product
   localparam int MW    = 2 * DW;          // product of dots
   localparam int NW    = MW + 3;          // determinant and numerators
   localparam int FB    = WEIGHT_FRAC_BITS;
   localparam int WB    = WEIGHT_FRAC_BITS + 4;
   localparam int RW    = NW + FB + WB + 2; // divider remainder
   localparam int OUT_W = ((3 * WB + 7) / 8) * 8;
   localparam int NV    = 8 + WB;          // stages ahead of the output register
   localparam int AX    = bary_pkg::AXES;
   localparam int NWT   = bary_pkg::WEIGHTS;

   logic en;

   // ---------------------------------------------------------------- fields
   logic signed [CW-1:0] ca [AX];
   logic signed [CW-1:0] cb [AX];
   logic signed [CW-1:0] cc [AX];
   logic signed [CW-1:0] cq [AX];

   always_comb begin
      for (int k = 0; k < AX; k++) begin
         ca[k] = req_tdata[k*CW +: CW];
         cb[k] = req_tdata[(AX+k)*CW +: CW];
         cc[k] = req_tdata[(2*AX+k)*CW +: CW];
         cq[k] = req_tdata[(3*AX+k)*CW +: CW];
      end
   end

   // ---------------------------------------------------------------- stages
   logic [NV-1:0] vld_ff;

   logic signed [EW-1:0] e0_ff [AX];
   logic signed [EW-1:0] e1_ff [AX];
   logic signed [EW-1:0] e2_ff [AX];

   logic signed [PW-1:0] p00_ff [AX];
   logic signed [PW-1:0] p01_ff [AX];
   logic signed [PW-1:0] p11_ff [AX];
   logic signed [PW-1:0] p20_ff [AX];
   logic signed [PW-1:0] p21_ff [AX];

   logic signed [DW-1:0] d00_ff, d01_ff, d11_ff, d20_ff, d21_ff;

   logic signed [MW-1:0] m_den_a_ff, m_den_b_ff;
   logic signed [MW-1:0] m_v_a_ff, m_v_b_ff, m_w_a_ff, m_w_b_ff;

   logic signed [NW-1:0] den_ff, nv_ff, nw_ff;

   logic signed [NW-1:0] s6_den_ff;
   logic signed [NW-1:0] s6_num_ff [NWT];
   logic                 s6_degen_ff;

   logic [RW-1:0]  n2_ff [NWT];
   logic [RW-1:0]  d2_ff;
   logic [NWT-1:0] s7_neg_ff;
   logic           s7_degen_ff;

   // divider: index 0 is the range check, index g holds g quotient bits
   logic [RW-1:0]  dv_rem_ff   [WB+1][NWT];
   logic [WB-1:0]  dv_q_ff     [WB+1][NWT];
   logic [RW-1:0]  dv_d2_ff    [WB+1];
   logic [NWT-1:0] dv_ovf_ff   [WB+1];
   logic [NWT-1:0] dv_neg_ff   [WB+1];
   logic           dv_degen_ff [WB+1];

   logic              rsp_valid_ff;
   logic [WB-1:0]     rsp_weight_ff [NWT];
   logic              rsp_degen_ff;

   // advance everything when the output register is free or being taken
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[NV-2:0], req_tvalid};
         rsp_valid_ff <= vld_ff[NV-1];
      end
   end

   // setup stages: edges, products, dots, products of dots, numerators, range check
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < AX; k++) begin
            e0_ff[k] <= EW'(cb[k]) - EW'(ca[k]);
            e1_ff[k] <= EW'(cc[k]) - EW'(ca[k]);
            e2_ff[k] <= EW'(cq[k]) - EW'(ca[k]);

            p00_ff[k] <= e0_ff[k] * e0_ff[k];
            p01_ff[k] <= e0_ff[k] * e1_ff[k];
            p11_ff[k] <= e1_ff[k] * e1_ff[k];
            p20_ff[k] <= e2_ff[k] * e0_ff[k];
            p21_ff[k] <= e2_ff[k] * e1_ff[k];
         end

         d00_ff <= DW'(p00_ff[0]) + DW'(p00_ff[1]) + DW'(p00_ff[2]);
         d01_ff <= DW'(p01_ff[0]) + DW'(p01_ff[1]) + DW'(p01_ff[2]);
         d11_ff <= DW'(p11_ff[0]) + DW'(p11_ff[1]) + DW'(p11_ff[2]);
         d20_ff <= DW'(p20_ff[0]) + DW'(p20_ff[1]) + DW'(p20_ff[2]);
         d21_ff <= DW'(p21_ff[0]) + DW'(p21_ff[1]) + DW'(p21_ff[2]);

         m_den_a_ff <= d00_ff * d11_ff;
         m_den_b_ff <= d01_ff * d01_ff;
         m_v_a_ff   <= d11_ff * d20_ff;
         m_v_b_ff   <= d01_ff * d21_ff;
         m_w_a_ff   <= d00_ff * d21_ff;
         m_w_b_ff   <= d01_ff * d20_ff;

         den_ff <= NW'(m_den_a_ff) - NW'(m_den_b_ff);
         nv_ff  <= NW'(m_v_a_ff) - NW'(m_v_b_ff);
         nw_ff  <= NW'(m_w_a_ff) - NW'(m_w_b_ff);

         // u numerator closes the sum so that the three numerators add up to exactly den
         s6_den_ff                  <= den_ff;
         s6_num_ff[bary_pkg::IDX_U] <= den_ff - nv_ff - nw_ff;
         s6_num_ff[bary_pkg::IDX_V] <= nv_ff;
         s6_num_ff[bary_pkg::IDX_W] <= nw_ff;
         s6_degen_ff                <= (den_ff == '0);

         // scale magnitude by 2^(F+1) and add den: rounds half away from zero
         for (int k = 0; k < NWT; k++) begin
            s7_neg_ff[k] <= s6_num_ff[k][NW-1];
            n2_ff[k]     <= (RW'($unsigned(s6_num_ff[k][NW-1] ? -s6_num_ff[k]
                                                             : s6_num_ff[k]))
                             << (FB + 1))
                            + RW'($unsigned(s6_den_ff));
         end
         d2_ff       <= RW'($unsigned(s6_den_ff)) << 1;
         s7_degen_ff <= s6_degen_ff;

         // range check: a quotient of WB bits or more always saturates
         for (int k = 0; k < NWT; k++) begin
            dv_rem_ff[0][k] <= n2_ff[k];
            dv_q_ff[0][k]   <= '0;
            dv_ovf_ff[0][k] <= (n2_ff[k] >= (d2_ff << WB));
         end
         dv_d2_ff[0]    <= d2_ff;
         dv_neg_ff[0]   <= s7_neg_ff;
         dv_degen_ff[0] <= s7_degen_ff;
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar g = 1; g <= WB; g++) begin : g_div
      logic [RW-1:0] trial;
      logic [RW-1:0] rem_in [NWT];
      logic [WB-1:0] q_in   [NWT];

      assign trial = dv_d2_ff[g-1] << (WB - g);

      always_comb begin
         for (int k = 0; k < NWT; k++) begin
            rem_in[k] = dv_rem_ff[g-1][k];
            q_in[k]   = dv_q_ff[g-1][k];
            if (dv_rem_ff[g-1][k] >= trial) begin
               rem_in[k]       = dv_rem_ff[g-1][k] - trial;
               q_in[k][WB - g] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_rem_ff[g]   <= rem_in;
            dv_q_ff[g]     <= q_in;
            dv_d2_ff[g]    <= dv_d2_ff[g-1];
            dv_ovf_ff[g]   <= dv_ovf_ff[g-1];
            dv_neg_ff[g]   <= dv_neg_ff[g-1];
            dv_degen_ff[g] <= dv_degen_ff[g-1];
         end
      end
   end

   // ---------------------------------------------------------------- output
   logic [WB-1:0] weight_in [NWT];

   always_comb begin
      logic [WB-1:0] lim;
      logic [WB-1:0] mag;
      for (int k = 0; k < NWT; k++) begin
         lim = dv_neg_ff[WB][k] ? {1'b1, {(WB-1){1'b0}}} : {1'b0, {(WB-1){1'b1}}};
         mag = (dv_ovf_ff[WB][k] || (dv_q_ff[WB][k] > lim)) ? lim : dv_q_ff[WB][k];
         if (dv_degen_ff[WB]) begin
            weight_in[k] = '0;
         end else if (dv_neg_ff[WB][k]) begin
            weight_in[k] = -mag;
         end else begin
            weight_in[k] = mag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_weight_ff <= weight_in;
         rsp_degen_ff  <= dv_degen_ff[WB];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_degen_ff;
   assign rsp_tdata  = OUT_W'({rsp_weight_ff[bary_pkg::IDX_W],
                               rsp_weight_ff[bary_pkg::IDX_V],
                               rsp_weight_ff[bary_pkg::IDX_U]});

endmodule
